// File: rtl/plcm_pkg.sv
// Shared types and constants for the piecewise linear colormap core.
// Holds the configuration register layout, the register indexes and the color stop table.
// No dependencies.
`default_nettype none

package plcm_pkg;

	localparam int DATA_W = 32;
	localparam int STOP_W = 11;
	localparam int DELTA_W = STOP_W + 1;
	localparam int NUM_STOPS = 5;
	localparam int NUM_CHANS = 3;

	typedef logic [STOP_W-1:0] stop_t;
	typedef logic signed [DELTA_W-1:0] delta_t;

	typedef enum logic [1:0] {
		REG_RANGE_LOW = 2'd0,
		REG_RANGE_HIGH = 2'd1,
		REG_PARTITION_SCALE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] range_low;
		logic signed [DATA_W-1:0] range_high;
		logic [DATA_W-1:0] partition_scale;
	} cfg_t;

	typedef struct packed {
		stop_t c0;
		delta_t d;
	} chan_coef_t;

	localparam logic signed [DATA_W-1:0] RANGE_LOW_RST = 32'sd0;
	localparam logic signed [DATA_W-1:0] RANGE_HIGH_RST = 32'sd65536;
	localparam logic [DATA_W-1:0] PARTITION_SCALE_RST = 32'd262144;

	// Stop colors in units of 1/1020, so that color * 255 * 4 is an exact integer.
	localparam stop_t STOP_LEVEL [NUM_STOPS][NUM_CHANS] = '{
		'{11'd0, 11'd0, 11'd510},
		'{11'd0, 11'd357, 11'd153},
		'{11'd357, 11'd357, 11'd357},
		'{11'd1020, 11'd357, 11'd102},
		'{11'd1020, 11'd1020, 11'd0}
	};

	function automatic chan_coef_t stop_coef(input logic [1:0] seg, input logic [1:0] ch);
		logic [2:0] idx0;
		logic [2:0] idx1;
		chan_coef_t coef;
		idx0 = {1'b0, seg};
		idx1 = idx0 + 3'd1;
		coef.c0 = STOP_LEVEL[idx0][ch];
		coef.d = $signed({1'b0, STOP_LEVEL[idx1][ch]}) - $signed({1'b0, STOP_LEVEL[idx0][ch]});
		return coef;
	endfunction

endpackage

`default_nettype wire

// File: rtl/plcm_cfg_regs.sv
// Configuration register file of the piecewise linear colormap core.
// Depends on plcm_pkg for the register layout and the register indexes.
`default_nettype none

module plcm_cfg_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic [1:0] cfg_index,
	input wire logic [plcm_pkg::DATA_W-1:0] cfg_data,
	output plcm_pkg::cfg_t cfg
);

	plcm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low <= plcm_pkg::RANGE_LOW_RST;
			cfg_q.range_high <= plcm_pkg::RANGE_HIGH_RST;
			cfg_q.partition_scale <= plcm_pkg::PARTITION_SCALE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				plcm_pkg::REG_RANGE_LOW: cfg_q.range_low <= $signed(cfg_data);
				plcm_pkg::REG_RANGE_HIGH: cfg_q.range_high <= $signed(cfg_data);
				plcm_pkg::REG_PARTITION_SCALE: cfg_q.partition_scale <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/plcm_front.sv
// Front stages of the colormap pipeline: range compare, offset, scale multiply, interval decode.
// Produces per channel base level and slope with the interpolation fraction.
// Depends on plcm_pkg.
`default_nettype none

module plcm_front #(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic signed [plcm_pkg::DATA_W-1:0] pixel_value,
	input wire plcm_pkg::cfg_t cfg,
	output logic valid_s3,
	output plcm_pkg::chan_coef_t coef_s3 [plcm_pkg::NUM_CHANS],
	output logic [FRAC_BITS:0] frac_s3
);

	localparam int PROD_W = 2 * plcm_pkg::DATA_W;
	localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic valid_s1;
	logic low_s1;
	logic high_s1;
	logic [plcm_pkg::DATA_W-1:0] diff_s1;

	logic valid_s2;
	logic low_s2;
	logic high_s2;
	logic [PROD_W-1:0] prod_s2;

	logic ge4;
	logic [1:0] seg;
	logic [FRAC_BITS:0] frac;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		low_s1 <= pixel_value <= cfg.range_low;
		high_s1 <= pixel_value >= cfg.range_high;
		diff_s1 <= pixel_value - cfg.range_low;
	end

	always_ff @(posedge clk) begin
		low_s2 <= low_s1;
		high_s2 <= high_s1;
		prod_s2 <= PROD_W'(diff_s1) * PROD_W'(cfg.partition_scale);
	end

	// A value at or below the low end uses the start of the first interval, and a value at
	// or above the high end, or a scaled offset of four or more, uses the end of the last.
	always_comb begin
		ge4 = |prod_s2[PROD_W-1:2*FRAC_BITS+2];
		if (low_s2) begin
			seg = 2'd0;
			frac = '0;
		end else if (high_s2 || ge4) begin
			seg = 2'd3;
			frac = FRAC_ONE;
		end else begin
			seg = prod_s2[2*FRAC_BITS+1:2*FRAC_BITS];
			frac = {1'b0, prod_s2[2*FRAC_BITS-1:FRAC_BITS]};
		end
	end

	always_ff @(posedge clk) begin
		frac_s3 <= frac;
		for (int ch = 0; ch < plcm_pkg::NUM_CHANS; ch++) begin
			coef_s3[ch] <= plcm_pkg::stop_coef(seg, 2'(ch));
		end
	end

endmodule

`default_nettype wire

// File: rtl/plcm_lerp.sv
// Back stages for one color channel: linear blend of two stops, then scale, clamping to 0..255 and truncation.
// Depends on plcm_pkg for the stop level and slope types.
`default_nettype none

module plcm_lerp #(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire plcm_pkg::chan_coef_t coef_s3,
	input wire logic [FRAC_BITS:0] frac_s3,
	output logic [7:0] level_s5
);

	localparam int NUM_W = FRAC_BITS + plcm_pkg::DELTA_W + 1;
	localparam int LVL_W = NUM_W - FRAC_BITS - 3;

	logic signed [NUM_W-1:0] base;
	logic signed [NUM_W-1:0] d_ext;
	logic signed [NUM_W-1:0] frac_ext;
	logic signed [NUM_W-1:0] num_s4;
	logic [LVL_W-1:0] level_wide;

	always_comb begin
		base = $signed({2'b00, coef_s3.c0, {FRAC_BITS{1'b0}}});
		d_ext = {{(NUM_W-plcm_pkg::DELTA_W){coef_s3.d[plcm_pkg::DELTA_W-1]}}, coef_s3.d};
		frac_ext = $signed({{(NUM_W-FRAC_BITS-1){1'b0}}, frac_s3});
	end

	always_ff @(posedge clk) begin
		num_s4 <= base + d_ext * frac_ext;
	end

	assign level_wide = num_s4[NUM_W-2:FRAC_BITS+2];

	always_ff @(posedge clk) begin
		if (num_s4[NUM_W-1]) begin
			level_s5 <= 8'd0;
		end else if (level_wide > LVL_W'(255)) begin
			level_s5 <= 8'd255;
		end else begin
			level_s5 <= level_wide[7:0];
		end
	end

endmodule

`default_nettype wire

// File: rtl/piecewise_linear_colormap_core.sv
// The done strobe follows the start transfer through the valid registers valid_s1 to valid_s5.
// Throughput is one pixel per cycle, through the 32 by 32 bit scale multiplier stage.
// The receiver cannot stall, so busy stays low and no pixel is ever held back.
// An asynchronous reset clears the valid pipeline and loads the default range of zero to one.
// Depends on plcm_pkg, plcm_cfg_regs, plcm_front and plcm_lerp.
`default_nettype none

module piecewise_linear_colormap_core #(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [31:0] pixel_value,
	output logic done,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data
);

	plcm_pkg::cfg_t cfg;
	plcm_pkg::chan_coef_t coef_s3 [plcm_pkg::NUM_CHANS];
	logic [FRAC_BITS:0] frac_s3;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;
	logic [7:0] level_s5 [plcm_pkg::NUM_CHANS];

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	plcm_cfg_regs u_cfg_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	plcm_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(start && !busy),
		.pixel_value(pixel_value),
		.cfg(cfg),
		.valid_s3(valid_s3),
		.coef_s3(coef_s3),
		.frac_s3(frac_s3)
	);

	for (genvar ch = 0; ch < plcm_pkg::NUM_CHANS; ch++) begin : g_chan
		plcm_lerp #(
			.FRAC_BITS(FRAC_BITS)
		) u_lerp (
			.clk(clk),
			.coef_s3(coef_s3[ch]),
			.frac_s3(frac_s3),
			.level_s5(level_s5[ch])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	assign done = valid_s5;
	assign red = level_s5[0];
	assign green = level_s5[1];
	assign blue = level_s5[2];

endmodule

`default_nettype wire
